@@ rtl/rotational_anisotropy_6_3_field_assert.svh @@
// Assertion macros for the rotational anisotropy field block.
`ifndef ROTATIONAL_ANISOTROPY_6_3_FIELD_ASSERT_SVH
`define ROTATIONAL_ANISOTROPY_6_3_FIELD_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, switched off while reset is high.
`define RAF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("raf: same-cycle check failed");
// Next-cycle implication, switched off while reset is high.
`define RAF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("raf: next-cycle check failed");
// Next-cycle implication that also holds across reset.
`define RAF_ASSERT_NXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("raf: reset check failed");
`else
`define RAF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RAF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`define RAF_ASSERT_NXT_NR(lbl, clk, ante, cons)
`endif
`endif

@@ rtl/raf_pkg.sv @@
// Shared widths, codes, types and helpers of the rotational anisotropy field block.
package raf_pkg;

   // Field widths of the channels.
   localparam int MAT_W    = 4;
   localparam int SEL_W    = 3;
   localparam int COEF_W   = 32;
   localparam int SPIN_W   = 32;
   localparam int FIELD_W  = 48;
   localparam int NUM_COEF = 7;

   // Fixed point shift of the multiplier products in the main datapath.
   localparam int QSH = 30;

   // Internal datapath widths, sized from the value ranges.
   localparam int P1_W   = 34;
   localparam int SZ_W   = 36;
   localparam int SQ_W   = 40;
   localparam int K_W    = 37;
   localparam int S4_W   = 46;
   localparam int KS_W   = 41;
   localparam int NUM_W  = 45;
   localparam int POLY_W = 50;
   localparam int T_W    = 56;
   localparam int TE_W   = 60;
   localparam int XC_W   = 58;
   localparam int CT_W   = 60;
   localparam int SUM_W  = 62;

   // Three in Q.30.
   localparam logic signed [NUM_W-1:0] THREE_Q30 = 45'sd3221225472;

   // Division by eleven: reciprocal floor(2^48 / 11) and its shift.
   localparam int DIV_SH  = 48;
   localparam int DIV_M_W = 46;
   localparam logic signed [DIV_M_W-1:0] DIV_M = 46'sd25588634246423;
   localparam int REM_W = 5;
   localparam logic [REM_W-1:0] DIV_D = 5'd11;

   // Request codes.
   localparam logic REQ_COMPUTE = 1'b0;
   localparam logic REQ_LOAD    = 1'b1;

   // Data that travels alongside the arithmetic.
   typedef struct packed {
      logic                               active;
      logic [2:0][FIELD_W-1:0]            field;
      logic [NUM_COEF-1:0][COEF_W-1:0]    coef;
   } raf_side_type;

   // Clamp a wide sum to the signed field range.
   function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-FIELD_W:0] hi;
      hi = v[SUM_W-1:FIELD_W-1];
      if (hi == '0 || hi == '1) begin
         return v[FIELD_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(FIELD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(FIELD_W-1){1'b1}}};
      end
   endfunction

endpackage

@@ rtl/raf_if.sv @@
// Channel interfaces of the rotational anisotropy field block.
interface raf_req_if import raf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [MAT_W-1:0]           material;
   logic [SEL_W-1:0]           coef_select;
   logic signed [COEF_W-1:0]   coef_value;
   logic signed [SPIN_W-1:0]   spin_x;
   logic signed [SPIN_W-1:0]   spin_y;
   logic signed [SPIN_W-1:0]   spin_z;
   logic signed [FIELD_W-1:0]  field_x;
   logic signed [FIELD_W-1:0]  field_y;
   logic signed [FIELD_W-1:0]  field_z;

   modport source (output valid, req_type, material, coef_select, coef_value,
                   spin_x, spin_y, spin_z, field_x, field_y, field_z, input ready);
   modport sink (input valid, req_type, material, coef_select, coef_value,
                 spin_x, spin_y, spin_z, field_x, field_y, field_z, output ready);
endinterface

interface raf_rsp_if import raf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [FIELD_W-1:0]  new_field_x;
   logic signed [FIELD_W-1:0]  new_field_y;
   logic signed [FIELD_W-1:0]  new_field_z;
   logic signed [FIELD_W-1:0]  energy;

   modport source (output valid, new_field_x, new_field_y, new_field_z, energy, input ready);
   modport sink (input valid, new_field_x, new_field_y, new_field_z, energy, output ready);
endinterface

interface raf_csr_if ();
   logic valid;
   logic ready;
   logic enable;

   modport source (output valid, enable, input ready);
   modport sink (input valid, enable, output ready);
endinterface

@@ rtl/rotational_anisotropy_6_3_field.sv @@
// Top level of the rotational anisotropy field block.
//
// Channels: req_if carries load and compute requests, rsp_if carries one result per
// compute request, csr_if writes the enable bit. Every channel moves a transfer at a
// clock edge where valid and ready are both high; csr_if is always ready.
// A load request writes one word of a material's coefficients into one of seven
// coefficient RAMs, one per word, and gives no result. A compute request reads all
// seven words of its material together and flows through a fixed pipeline of 21
// register stages built from dedicated multiplier and divider units. Its result is
// valid on rsp_if from the output register of the last stage, and the result transfer
// follows once rsp_if.ready is high. Throughput is one request per cycle while the
// receiver does not stall, set by the single RAM read per request and the fully
// pipelined multipliers. A load followed by a compute of the same material in
// the next cycle sees the new word, since the write lands before the read.
// Reset clears the enable bit and all valid flags; the RAM contents are not cleared,
// and each word must be loaded before a compute request reads it.
// When the receiver stalls, the whole pipeline holds and req_if.ready falls until the
// waiting result is taken.
module rotational_anisotropy_6_3_field import raf_pkg::*; #(
   parameter int NUM_MATERIALS = 16
) (
   input  logic       clock,
   input  logic       reset,
   raf_req_if.sink    req_if,
   raf_rsp_if.source  rsp_if,
   raf_csr_if.sink    csr_if
);

   `include "rotational_anisotropy_6_3_field_assert.svh"

   localparam int AW     = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;
   localparam int MW     = (AW > MAT_W) ? AW : MAT_W;
   localparam int ST_OUT = 20;

   logic                   enable_ff;
   logic                   adv;
   logic                   req_fire;
   logic                   in_range;
   logic [MW-1:0]          mat_ext;
   logic [AW-1:0]          addr;
   logic [ST_OUT:0]        vld_ff;
   logic [COEF_W-1:0]      coef_rd [NUM_COEF];
   logic signed [SPIN_W-1:0]  spin_ff [3];
   logic signed [FIELD_W-1:0] fld0_ff [3];
   logic                   act0_ff;
   raf_side_type           side_t0;
   raf_side_type           side_ff [1:19];

   logic signed [P1_W-1:0] p1 [6];
   logic signed [SZ_W-1:0] sz_ff, sx_ff;
   logic signed [SZ_W-1:0] szd_ff [4:5];
   logic signed [SQ_W-1:0] sz2, sx2;
   logic signed [K_W-1:0]  kz, kx;
   logic signed [SQ_W-1:0] sz2d_ff [6:7];
   logic signed [SQ_W-1:0] sx2d_ff [6:7];
   logic signed [K_W-1:0]  kzd_ff [6:14];
   logic signed [K_W-1:0]  kxd_ff [6:14];
   logic signed [S4_W-1:0] sz4, sx2sz2;
   logic signed [KS_W-1:0] kxsz;
   logic signed [KS_W-1:0] kxszd_ff [8:14];
   logic signed [NUM_W-1:0] nx_ff, nz_ff, ne_ff;
   logic signed [NUM_W-1:0] qx, qz, qe;
   logic signed [POLY_W-1:0] ax_ff [8:13];
   logic signed [POLY_W-1:0] az_ff [8:13];
   logic signed [POLY_W-1:0] ae_ff [8:13];
   logic signed [POLY_W-1:0] px_ff, pz_ff, pe_ff;
   logic signed [T_W-1:0]  tx, tz;
   logic signed [TE_W-1:0] te;
   logic signed [XC_W-1:0] xc_ff, zc_ff;
   logic signed [TE_W-1:0] e_ff [17:19];
   logic signed [CT_W-1:0] tzc [3];
   logic signed [CT_W-1:0] txc [3];
   logic signed [SUM_W-1:0] fsum [3];
   logic signed [FIELD_W-1:0] nf_ff [3];
   logic signed [FIELD_W-1:0] energy_ff;
   logic                   act_out_ff;

   // Configuration register.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_if.valid) begin
         enable_ff <= csr_if.enable;
      end
   end

   // The pipeline advances unless a finished result is held up.
   assign adv          = !vld_ff[ST_OUT] || rsp_if.ready;
   assign req_if.ready = adv;
   assign req_fire     = req_if.valid && adv;
   assign in_range     = int'(req_if.material) < NUM_MATERIALS;
   assign mat_ext      = MW'(req_if.material);
   assign addr         = mat_ext[AW-1:0];

   // Coefficient RAMs, one per word of a material.
   for (genvar w = 0; w < NUM_COEF; w++) begin : g_coef
      raf_ram #(.WIDTH(COEF_W), .DEPTH(NUM_MATERIALS)) u_ram (
         .clock  (clock),
         .wr_en  (req_fire && req_if.req_type == REQ_LOAD && in_range
                  && req_if.coef_select == SEL_W'(w)),
         .wr_addr(addr),
         .wr_data(req_if.coef_value),
         .rd_en  (adv),
         .rd_addr(addr),
         .rd_data(coef_rd[w])
      );
   end

   // Valid flags of the pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:0], req_fire && req_if.req_type == REQ_COMPUTE};
      end
   end

   // Request registers, aligned with the RAM read data.
   always_ff @(posedge clock) begin
      if (adv) begin
         spin_ff[0] <= req_if.spin_x;
         spin_ff[1] <= req_if.spin_y;
         spin_ff[2] <= req_if.spin_z;
         fld0_ff[0] <= req_if.field_x;
         fld0_ff[1] <= req_if.field_y;
         fld0_ff[2] <= req_if.field_z;
         act0_ff    <= enable_ff && in_range;
      end
   end

   // Side data that rides along with the arithmetic.
   always_comb begin
      side_t0.active = act0_ff;
      for (int i = 0; i < 3; i++) begin
         side_t0.field[i] = fld0_ff[i];
      end
      for (int w = 0; w < NUM_COEF; w++) begin
         side_t0.coef[w] = coef_rd[w];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[1] <= side_t0;
         for (int k = 2; k <= 19; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Projections onto the two axes.
   for (genvar j = 0; j < 6; j++) begin : g_proj
      raf_mulq #(.WA(SPIN_W), .WB(COEF_W), .WO(P1_W), .SH(QSH)) u_mul (
         .clock(clock), .en(adv), .a(spin_ff[j % 3]), .b($signed(coef_rd[j])), .p(p1[j])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sz_ff <= SZ_W'(p1[0]) + SZ_W'(p1[1]) + SZ_W'(p1[2]);
         sx_ff <= SZ_W'(p1[3]) + SZ_W'(p1[4]) + SZ_W'(p1[5]);
      end
   end

   // Squares of the projections and the constant times each projection.
   raf_mulq #(.WA(SZ_W), .WB(SZ_W), .WO(SQ_W), .SH(QSH)) u_sz2 (
      .clock(clock), .en(adv), .a(sz_ff), .b(sz_ff), .p(sz2)
   );
   raf_mulq #(.WA(SZ_W), .WB(SZ_W), .WO(SQ_W), .SH(QSH)) u_sx2 (
      .clock(clock), .en(adv), .a(sx_ff), .b(sx_ff), .p(sx2)
   );
   raf_mulq #(.WA(COEF_W), .WB(SZ_W), .WO(K_W), .SH(QSH)) u_kz (
      .clock(clock), .en(adv), .a($signed(side_ff[3].coef[6])), .b(sz_ff), .p(kz)
   );
   raf_mulq #(.WA(COEF_W), .WB(SZ_W), .WO(K_W), .SH(QSH)) u_kx (
      .clock(clock), .en(adv), .a($signed(side_ff[3].coef[6])), .b(sx_ff), .p(kx)
   );

   // Fourth-order terms and the energy prefactor.
   raf_mulq #(.WA(SQ_W), .WB(SQ_W), .WO(S4_W), .SH(QSH)) u_sz4 (
      .clock(clock), .en(adv), .a(sz2), .b(sz2), .p(sz4)
   );
   raf_mulq #(.WA(SQ_W), .WB(SQ_W), .WO(S4_W), .SH(QSH)) u_sx2sz2 (
      .clock(clock), .en(adv), .a(sx2), .b(sz2), .p(sx2sz2)
   );
   raf_mulq #(.WA(K_W), .WB(SZ_W), .WO(KS_W), .SH(QSH)) u_kxsz (
      .clock(clock), .en(adv), .a(kx), .b(szd_ff[5]), .p(kxsz)
   );

   // Delay lines that keep operands in step.
   always_ff @(posedge clock) begin
      if (adv) begin
         szd_ff[4]  <= sz_ff;
         szd_ff[5]  <= szd_ff[4];
         sz2d_ff[6] <= sz2;
         sz2d_ff[7] <= sz2d_ff[6];
         sx2d_ff[6] <= sx2;
         sx2d_ff[7] <= sx2d_ff[6];
         kzd_ff[6]  <= kz;
         kxd_ff[6]  <= kx;
         for (int k = 7; k <= 14; k++) begin
            kzd_ff[k] <= kzd_ff[k-1];
            kxd_ff[k] <= kxd_ff[k-1];
         end
         kxszd_ff[8] <= kxsz;
         for (int k = 9; k <= 14; k++) begin
            kxszd_ff[k] <= kxszd_ff[k-1];
         end
      end
   end

   // Polynomial numerators and leading terms.
   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= NUM_W'(sz2d_ff[7]) * 14 + NUM_W'(sx2d_ff[7]) * 12 - THREE_Q30;
         nz_ff <= NUM_W'(sz2d_ff[7]) * 42 + NUM_W'(sx2d_ff[7]) * 4 - THREE_Q30;
         ne_ff <= (NUM_W'(sz2d_ff[7]) * 14 + NUM_W'(sx2d_ff[7]) * 4 - THREE_Q30) * 3;
         ax_ff[8] <= POLY_W'(sz4) + POLY_W'(sx2sz2) * 4;
         az_ff[8] <= POLY_W'(sz4) * 5 + POLY_W'(sx2sz2) * 4;
         ae_ff[8] <= POLY_W'(sz4) * 3 + POLY_W'(sx2sz2) * 4;
         for (int k = 9; k <= 13; k++) begin
            ax_ff[k] <= ax_ff[k-1];
            az_ff[k] <= az_ff[k-1];
            ae_ff[k] <= ae_ff[k-1];
         end
      end
   end

   // Divisions by eleven.
   raf_div11 u_divx (.clock(clock), .en(adv), .n(nx_ff), .q(qx));
   raf_div11 u_divz (.clock(clock), .en(adv), .n(nz_ff), .q(qz));
   raf_div11 u_dive (.clock(clock), .en(adv), .n(ne_ff), .q(qe));

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= ax_ff[13] - POLY_W'(qx);
         pz_ff <= az_ff[13] - POLY_W'(qz);
         pe_ff <= ae_ff[13] - POLY_W'(qe);
      end
   end

   // Component scales and the energy product.
   raf_mulq #(.WA(K_W), .WB(POLY_W), .WO(T_W), .SH(QSH)) u_tx (
      .clock(clock), .en(adv), .a(kzd_ff[14]), .b(px_ff), .p(tx)
   );
   raf_mulq #(.WA(K_W), .WB(POLY_W), .WO(T_W), .SH(QSH)) u_tz (
      .clock(clock), .en(adv), .a(kxd_ff[14]), .b(pz_ff), .p(tz)
   );
   raf_mulq #(.WA(KS_W), .WB(POLY_W), .WO(TE_W), .SH(QSH)) u_te (
      .clock(clock), .en(adv), .a(kxszd_ff[14]), .b(pe_ff), .p(te)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         xc_ff     <= XC_W'(tx) * 3;
         zc_ff     <= XC_W'(tz) * 3;
         e_ff[17]  <= -te;
         e_ff[18]  <= e_ff[17];
         e_ff[19]  <= e_ff[18];
      end
   end

   // Projections of the components back onto the axes.
   for (genvar i = 0; i < 3; i++) begin : g_back
      raf_mulq #(.WA(COEF_W), .WB(XC_W), .WO(CT_W), .SH(QSH)) u_zc (
         .clock(clock), .en(adv), .a($signed(side_ff[17].coef[i])), .b(zc_ff), .p(tzc[i])
      );
      raf_mulq #(.WA(COEF_W), .WB(XC_W), .WO(CT_W), .SH(QSH)) u_xc (
         .clock(clock), .en(adv), .a($signed(side_ff[17].coef[3+i])), .b(xc_ff),
         .p(txc[i])
      );
      assign fsum[i] = SUM_W'($signed(side_ff[19].field[i])) + SUM_W'(tzc[i])
                       + SUM_W'(txc[i]);
   end

   // Output register: saturated sums, or the incoming field when bypassed.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            nf_ff[i] <= side_ff[19].active ? sat_field(fsum[i])
                                            : $signed(side_ff[19].field[i]);
         end
         energy_ff  <= side_ff[19].active ? sat_field(SUM_W'(e_ff[19])) : '0;
         act_out_ff <= side_ff[19].active;
      end
   end

   assign rsp_if.valid       = vld_ff[ST_OUT];
   assign rsp_if.new_field_x = nf_ff[0];
   assign rsp_if.new_field_y = nf_ff[1];
   assign rsp_if.new_field_z = nf_ff[2];
   assign rsp_if.energy      = energy_ff;

   // Checks on the pipeline control.
   `RAF_ASSERT_NXT_NR(a_reset_clears, clock, reset, !rsp_if.valid)
   `RAF_ASSERT_NXT(a_stall_holds, clock, reset, rsp_if.valid && !rsp_if.ready, $stable(vld_ff))
   `RAF_ASSERT_NXT(a_load_no_result, clock, reset, req_fire && req_if.req_type == REQ_LOAD, !vld_ff[0])
   `RAF_ASSERT_IMP(a_bypass_energy, clock, reset, vld_ff[ST_OUT] && !act_out_ff, energy_ff == '0)

endmodule

@@ rtl/raf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module raf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/raf_mulq.sv @@
// Two-stage signed multiplier with a truncating right shift toward zero.
module raf_mulq #(
   parameter int WA = 32,
   parameter int WB = 32,
   parameter int WO = 34,
   parameter int SH = 30
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [WA-1:0] a,
   input  logic signed [WB-1:0] b,
   output logic signed [WO-1:0] p
);

   localparam int LO = WB / 2;
   localparam int HI = WB - LO;
   localparam int WP = WA + WB;
   localparam logic [WP-1:0] RND = {{(WP-SH){1'b0}}, {SH{1'b1}}};

   logic signed [WA+LO:0]   pl_ff;
   logic signed [WA+HI-1:0] ph_ff;
   logic signed [WO-1:0]    p_ff;
   logic signed [WP-1:0]    full;
   logic signed [WP-1:0]    adj;
   logic signed [WP-1:0]    shv;

   // First stage: two partial products over the halves of b.
   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff <= a * $signed({1'b0, b[LO-1:0]});
         ph_ff <= a * $signed(b[WB-1:LO]);
      end
   end

   // Second stage: recombine, bias negative values and shift.
   always_comb begin
      full = (WP'(ph_ff) <<< LO) + WP'(pl_ff);
      adj  = full + $signed(full[WP-1] ? RND : '0);
      shv  = adj >>> SH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= shv[WO-1:0];
      end
   end

   assign p = p_ff;

endmodule

@@ rtl/raf_div11.sv @@
// Five-stage signed division by eleven, truncating toward zero.
module raf_div11 import raf_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] n,
   output logic signed [NUM_W-1:0] q
);

   logic                    neg_a_ff;
   logic [NUM_W-1:0]        mag_a_ff;
   logic [1:0]              neg_d_ff;
   logic [NUM_W-1:0]        mag_d_ff [2];
   logic signed [NUM_W-1:0] q0;
   logic [NUM_W-1:0]        rem_full;
   logic [REM_W-1:0]        rem_ff;
   logic [NUM_W-1:0]        q0_ff;
   logic                    neg_c_ff;
   logic [NUM_W-1:0]        qm;
   logic signed [NUM_W-1:0] q_ff;

   // Split into sign and magnitude.
   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff <= n[NUM_W-1];
         mag_a_ff <= n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
      end
   end

   // Quotient estimate from the reciprocal; it is low by at most one.
   raf_mulq #(
      .WA(NUM_W + 1), .WB(DIV_M_W), .WO(NUM_W), .SH(DIV_SH)
   ) u_recip (
      .clock(clock), .en(en), .a($signed({1'b0, mag_a_ff})), .b(DIV_M), .p(q0)
   );

   // Keep sign and magnitude in step with the multiplier.
   always_ff @(posedge clock) begin
      if (en) begin
         neg_d_ff    <= {neg_d_ff[0], neg_a_ff};
         mag_d_ff[0] <= mag_a_ff;
         mag_d_ff[1] <= mag_d_ff[0];
      end
   end

   // Remainder of the estimate.
   assign rem_full = mag_d_ff[1] - NUM_W'(q0) * NUM_W'(11);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff   <= rem_full[REM_W-1:0];
         q0_ff    <= q0;
         neg_c_ff <= neg_d_ff[1];
      end
   end

   // Correct the estimate and restore the sign.
   assign qm = q0_ff + NUM_W'(rem_ff >= DIV_D);

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= neg_c_ff ? $signed(-qm) : $signed(qm);
      end
   end

   assign q = q_ff;

endmodule
